[hdl/kabf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package kabf_pkg;

	localparam int unsigned DataW  = 32;
	localparam int unsigned NoiseW = 31;
	localparam int unsigned DtW    = 16;
	localparam int unsigned IdxW   = 2;
	localparam logic [NoiseW-1:0] NoiseReset = 31'd655;
	localparam logic signed [DataW-1:0] OneQ16 = 32'sd65536;

	localparam logic [IdxW-1:0] RegAngleQ = 2'd0;
	localparam logic [IdxW-1:0] RegBiasQ  = 2'd1;
	localparam logic [IdxW-1:0] RegMeasR  = 2'd2;

	// sequencer steps, one shared multiplier and one shared divider
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RATE,    // rate = gyro - bias
		ST_ANG,     // mul dt*rate
		ST_ANG_W,   // angle += product
		ST_T,       // mul dt*P11
		ST_T_W,     // t = product; s = t - P01 - P10 + Qa
		ST_P00,     // mul dt*s
		ST_P00_W,   // P00 +=, P01 -= t, P10 -= t
		ST_P11,     // mul Qb*dt
		ST_P11_W,   // P11 +=; start divide for k0
		ST_K0,      // wait divider
		ST_K1,      // wait divider, k1
		ST_Y,       // mul k0*y (y = meas - angle)
		ST_UA,      // angle +=; mul k1*y
		ST_UB,      // bias +=; mul k0*P00
		ST_U00,     // P00' ; mul k0*P01
		ST_U01,     // P01' ; mul k1*P00
		ST_U10,     // P10' ; mul k1*P01
		ST_U11,     // P11'
		ST_OUT
	} kabf_state_t;

	function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[DataW-1:0];
	endfunction

endpackage
`default_nettype wire

[hdl/kabf_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface kabf_in_if;
	logic                valid;
	logic                ready;
	logic signed [31:0]  measured_angle;
	logic signed [31:0]  gyro_rate;
	logic        [15:0]  time_step;
	modport source (output valid, measured_angle, gyro_rate, time_step, input ready);
	modport sink   (input valid, measured_angle, gyro_rate, time_step, output ready);
endinterface

interface kabf_out_if;
	logic                valid;
	logic                ready;
	logic signed [31:0]  filtered_angle;
	modport source (output valid, filtered_angle, input ready);
	modport sink   (input valid, filtered_angle, output ready);
endinterface
`default_nettype wire

[hdl/kalman_angle_bias_filter_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Two-state tilt Kalman filter (angle and gyro bias), signed Q16.16.
// Input channel in: measured_angle, gyro_rate, time_step (Q0.16 s).
// Output channel out: filtered_angle, one result per input transfer.
// Configuration: cfg_we/cfg_idx/cfg_data write the noise registers
// (0 angle process, 1 bias process, 2 measurement); other indexes ignored.
// Each item passes the idle step and 19 sequencer steps, with a
// shared 33x33 multiplier used for at most one product per step, and
// the gain divider producing two quotients, one quotient bit a cycle.
// The next input is taken only once the block is back in idle.
// in.ready is high only while idle.
// The result sits in an output register until taken. Meanwhile the next
// item is accepted and computed, then the block waits in its last step
// until the output register frees, and accepts nothing further.
// Reset clears the estimates, sets the covariance to identity and the
// noise registers to 655 (about 0.01).
module kalman_angle_bias_filter_top import kabf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	kabf_in_if.sink                in,
	kabf_out_if.source             out,
	input  wire logic              cfg_we,
	input  wire logic [IdxW-1:0]   cfg_idx,
	input  wire logic [NoiseW-1:0] cfg_data
);
	kabf_state_t st_q, st_d;

	logic [NoiseW-1:0] qa_q, qb_q, r_q;
	logic signed [DataW-1:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [DataW-1:0] meas_q, gyro_q, rate_q, t_q, s_q, k0_q, k1_q, y_q;
	logic signed [DataW-1:0] op00_q, op01_q;
	logic [DtW-1:0] dt_q;
	logic signed [DataW-1:0] prod_q;
	logic signed [DataW-1:0] res_q;
	logic                    ovalid_q;

	// shared multiplier operands
	logic signed [DataW:0] ma, mb;
	logic signed [65:0]    mprod;
	logic signed [DataW-1:0] mres;

	logic div_start, div_done;
	logic signed [DataW-1:0] div_num, div_q;
	logic signed [DataW:0]   div_den;

	kabf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_q)
	);

	assign div_den = $signed({p00_q[DataW-1], p00_q}) + $signed({2'b00, r_q});
	assign div_num = (st_q == ST_K0 && div_done) ? p10_q : p00_q;
	assign div_start = (st_q == ST_P11_W) || (st_q == ST_K0 && div_done);

	// operand select per step
	always_comb begin
		ma = '0;
		mb = '0;
		case (st_q)
			ST_ANG:  begin ma = {1'b0, 16'd0, dt_q}; mb = {rate_q[DataW-1], rate_q}; end
			ST_T:    begin ma = {1'b0, 16'd0, dt_q}; mb = {p11_q[DataW-1], p11_q}; end
			ST_P00:  begin ma = {1'b0, 16'd0, dt_q}; mb = {s_q[DataW-1], s_q}; end
			ST_P11:  begin ma = {2'b00, qb_q};       mb = {1'b0, 16'd0, dt_q}; end
			ST_Y:    begin ma = {k0_q[DataW-1], k0_q}; mb = {y_q[DataW-1], y_q}; end
			ST_UA:   begin ma = {k1_q[DataW-1], k1_q}; mb = {y_q[DataW-1], y_q}; end
			ST_UB:   begin ma = {k0_q[DataW-1], k0_q}; mb = {op00_q[DataW-1], op00_q}; end
			ST_U00:  begin ma = {k0_q[DataW-1], k0_q}; mb = {op01_q[DataW-1], op01_q}; end
			ST_U01:  begin ma = {k1_q[DataW-1], k1_q}; mb = {op00_q[DataW-1], op00_q}; end
			ST_U10:  begin ma = {k1_q[DataW-1], k1_q}; mb = {op01_q[DataW-1], op01_q}; end
			default: begin ma = '0; mb = '0; end
		endcase
		mprod = 66'(ma) * 66'(mb) + 66'sd32768;
		mres  = sat32(mprod >>> 16);
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:  if (in.valid) st_d = ST_RATE;
			ST_RATE:  st_d = ST_ANG;
			ST_ANG:   st_d = ST_ANG_W;
			ST_ANG_W: st_d = ST_T;
			ST_T:     st_d = ST_T_W;
			ST_T_W:   st_d = ST_P00;
			ST_P00:   st_d = ST_P00_W;
			ST_P00_W: st_d = ST_P11;
			ST_P11:   st_d = ST_P11_W;
			ST_P11_W: st_d = ST_K0;
			ST_K0:    if (div_done) st_d = ST_K1;
			ST_K1:    if (div_done) st_d = ST_Y;
			ST_Y:     st_d = ST_UA;
			ST_UA:    st_d = ST_UB;
			ST_UB:    st_d = ST_U00;
			ST_U00:   st_d = ST_U01;
			ST_U01:   st_d = ST_U10;
			ST_U10:   st_d = ST_U11;
			ST_U11:   st_d = ST_OUT;
			ST_OUT:   if (!ovalid_q || out.ready) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else         st_q <= st_d;
	end

	assign in.ready = (st_q == ST_IDLE);
	assign out.valid = ovalid_q;
	assign out.filtered_angle = res_q;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (st_q == ST_OUT && (!ovalid_q || out.ready)) ovalid_q <= 1'b1;
		else if (out.ready) ovalid_q <= 1'b0;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= NoiseReset;
			qb_q <= NoiseReset;
			r_q  <= NoiseReset;
		end else if (cfg_we) begin
			case (cfg_idx)
				RegAngleQ: qa_q <= cfg_data;
				RegBiasQ:  qb_q <= cfg_data;
				RegMeasR:  r_q  <= cfg_data;
				default:   ;
			endcase
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q  <= '0;
			bias_q <= '0;
			p00_q  <= OneQ16;
			p01_q  <= '0;
			p10_q  <= '0;
			p11_q  <= OneQ16;
		end else begin
			case (st_q)
				ST_ANG_W: ang_q <= sat32(66'(ang_q) + 66'(prod_q));
				ST_P00_W: begin
					p00_q <= sat32(66'(p00_q) + 66'(prod_q));
					p01_q <= sat32(66'(p01_q) - 66'(t_q));
					p10_q <= sat32(66'(p10_q) - 66'(t_q));
				end
				ST_P11_W: p11_q <= sat32(66'(p11_q) + 66'(prod_q));
				ST_UA:  ang_q  <= sat32(66'(ang_q) + 66'(prod_q));
				ST_UB:  bias_q <= sat32(66'(bias_q) + 66'(prod_q));
				ST_U00: p00_q  <= sat32(66'(op00_q) - 66'(prod_q));
				ST_U01: p01_q  <= sat32(66'(op01_q) - 66'(prod_q));
				ST_U10: p10_q  <= sat32(66'(p10_q) - 66'(prod_q));
				ST_U11: p11_q  <= sat32(66'(p11_q) - 66'(prod_q));
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		prod_q <= mres;
		if (st_q == ST_IDLE && in.valid) begin
			meas_q <= in.measured_angle;
			gyro_q <= in.gyro_rate;
			dt_q   <= in.time_step;
		end
		if (st_q == ST_RATE) rate_q <= sat32(66'(gyro_q) - 66'(bias_q));
		if (st_q == ST_T_W) begin
			t_q <= prod_q;
			s_q <= sat32(66'(prod_q) - 66'(p01_q) - 66'(p10_q) + $signed({35'd0, qa_q}));
		end
		if (st_q == ST_K0 && div_done) k0_q <= div_q;
		if (st_q == ST_K1 && div_done) begin
			k1_q   <= div_q;
			y_q    <= sat32(66'(meas_q) - 66'(ang_q));
			op00_q <= p00_q;
			op01_q <= p01_q;
		end
		// load the result only once the previous one has been taken
		if (st_q == ST_OUT && (!ovalid_q || out.ready)) res_q <= ang_q;
	end
endmodule
`default_nettype wire

[hdl/kabf_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// Signed restoring divider, one quotient bit a cycle: q = sat32((p<<16)/s), truncated.
module kabf_div import kabf_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [DataW-1:0]  num,
	input  wire logic signed [DataW:0]    den,
	output logic                          done,
	output logic signed [DataW-1:0]       quo
);
	localparam int unsigned NumW = DataW + 16;
	localparam int unsigned CntW = $clog2(NumW + 1);

	logic [NumW-1:0] n_q;
	logic [NumW-1:0] q_q;
	logic [DataW:0]  d_q;
	logic [DataW+1:0] r_q;
	logic            neg_q;
	logic            zero_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;

	logic [DataW+1:0] r_sh;
	logic [DataW+1:0] r_sub;
	logic [NumW-1:0]  num_abs;
	logic [DataW:0]   den_abs;
	logic signed [65:0] q_signed;

	always_comb begin
		num_abs = num[DataW-1] ? (~{num, 16'd0} + 1'b1) : {num, 16'd0};
		den_abs = den[DataW] ? (~den + 1'b1) : den;
		r_sh  = {r_q[DataW:0], n_q[NumW-1]};
		r_sub = r_sh - {1'b0, d_q};
		q_signed = neg_q ? -$signed({18'd0, q_q}) : $signed({18'd0, q_q});
	end

	// shift-subtract iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= num_abs;
			d_q    <= den_abs;
			r_q    <= '0;
			q_q    <= '0;
			neg_q  <= num[DataW-1] ^ den[DataW];
			zero_q <= (den == '0);
		end else if (busy_q) begin
			n_q <= {n_q[NumW-2:0], 1'b0};
			if (!r_sub[DataW+1]) begin
				r_q <= r_sub;
				q_q <= {q_q[NumW-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign quo = zero_q ? '0 : sat32(q_signed);
endmodule
`default_nettype wire

[test/kalman_angle_bias_filter_top_tb.sv]
`timescale 1ns / 1ps
import kabf_pkg::*;

// Tracks the filter state and queues the angle each accepted sample should produce
class tilt_scoreboard;
	longint qa, qb, r_noise;
	int angle, bias, p00, p01, p10, p11;
	int expected_angles[$];
	int errors, samples, results;

	function new();
		qa = NoiseReset; qb = NoiseReset; r_noise = NoiseReset;
		angle = 0; bias = 0;
		p00 = OneQ16; p01 = 0; p10 = 0; p11 = OneQ16;
		errors = 0; samples = 0; results = 0;
	endfunction

	function int clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return int'(v);
	endfunction

	// Q16.16 product, round half up, arithmetic shift floors
	function int qprod(longint a, longint b);
		longint p;
		p = a * b + 64'sd32768;
		return clamp32(p >>> 16);
	endfunction

	function int qdiv_gain(int p, longint s);
		if (s == 0) return 0;
		return clamp32((longint'(p) * 64'sd65536) / s);
	endfunction

	function void set_noise(logic [IdxW-1:0] idx, logic [NoiseW-1:0] val);
		case (idx)
			RegAngleQ: qa = longint'(val);
			RegBiasQ:  qb = longint'(val);
			RegMeasR:  r_noise = longint'(val);
			default: ;
		endcase
	endfunction

	function void note_sample(int meas, int gyro, logic [DtW-1:0] dt_in);
		longint dt, sv;
		int rate, t, s, k0, k1, y, o00, o01;
		dt = longint'(dt_in);
		// predict
		rate = clamp32(longint'(gyro) - longint'(bias));
		angle = clamp32(longint'(angle) + longint'(qprod(dt, rate)));
		t = qprod(dt, p11);
		s = clamp32(longint'(t) - longint'(p01) - longint'(p10) + qa);
		p00 = clamp32(longint'(p00) + longint'(qprod(dt, s)));
		p01 = clamp32(longint'(p01) - longint'(t));
		p10 = clamp32(longint'(p10) - longint'(t));
		p11 = clamp32(longint'(p11) + longint'(qprod(qb, dt)));
		// gains
		sv = longint'(p00) + r_noise;
		k0 = qdiv_gain(p00, sv);
		k1 = qdiv_gain(p10, sv);
		// measurement update, covariance from pre-update terms
		y = clamp32(longint'(meas) - longint'(angle));
		angle = clamp32(longint'(angle) + longint'(qprod(k0, y)));
		bias = clamp32(longint'(bias) + longint'(qprod(k1, y)));
		o00 = p00;
		o01 = p01;
		p00 = clamp32(longint'(o00) - longint'(qprod(k0, o00)));
		p01 = clamp32(longint'(o01) - longint'(qprod(k0, o01)));
		p10 = clamp32(longint'(p10) - longint'(qprod(k1, o00)));
		p11 = clamp32(longint'(p11) - longint'(qprod(k1, o01)));
		expected_angles.push_back(angle);
		samples++;
	endfunction

	function void check_angle(int actual);
		int exp_a;
		results++;
		if (expected_angles.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %0d", $time, actual);
			errors++;
			return;
		end
		exp_a = expected_angles.pop_front();
		if (exp_a !== actual) begin
			$display("%0t: filtered_angle mismatch, expected %0d, actual %0d",
				$time, exp_a, actual);
			errors++;
		end
	endfunction
endclass

module kalman_angle_bias_filter_top_tb;

	localparam int StallLimit = 5000;
	localparam int HoldCycles = 800;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IdxW-1:0] cfg_idx = '0;
	logic [NoiseW-1:0] cfg_data = '0;

	kabf_in_if in_ch();
	kabf_out_if out_ch();

	tilt_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;

	kalman_angle_bias_filter_top DUT (
		.clk(clk), .arst_n(arst_n), .in(in_ch.sink), .out(out_ch.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// transfers on both channels, plus the stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_sample(in_ch.measured_angle, in_ch.gyro_rate, in_ch.time_step);
			if (out_ch.valid && out_ch.ready)
				sb.check_angle(out_ch.filtered_angle);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= StallLimit) begin
				$display("%0t: watchdog, no transfer for %0d cycles", $time, StallLimit);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// receiver: random back-pressure, or one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
			end
			out_ch.ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic send_sample(int meas, int gyro, logic [DtW-1:0] dt_v);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 120)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.measured_angle <= meas;
		in_ch.gyro_rate <= gyro;
		in_ch.time_step <= dt_v;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_angles.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_noise(logic [IdxW-1:0] idx, logic [NoiseW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		sb.set_noise(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_sample(output int m, output int g, output logic [DtW-1:0] d);
		int pick;
		int corner[4] = '{32'sh7fffffff, 32'sh80000000, 0, -1};
		pick = $urandom_range(9);
		if (pick <= 6) begin
			// plausible IMU data: +-90 degrees, +-250 deg/s, short steps
			m = int'($urandom_range(0, 11796480)) - 5898240;
			g = int'($urandom_range(0, 32768000)) - 16384000;
			d = DtW'($urandom_range(0, 1000));
		end else if (pick == 7) begin
			m = $urandom;
			g = $urandom;
			d = DtW'($urandom_range(0, 65535));
		end else if (pick == 8) begin
			m = corner[$urandom_range(3)];
			g = corner[$urandom_range(3)];
			d = $urandom_range(1) ? 16'hffff : 16'h0000;
		end else begin
			m = int'($urandom_range(0, 11796480)) - 5898240;
			g = $urandom;
			d = DtW'($urandom_range(0, 65535));
		end
	endtask

	initial begin
		int m, g;
		logic [DtW-1:0] d;
		logic [NoiseW-1:0] cfg_sets [6][3];

		in_ch.valid = 1'b0;
		in_ch.measured_angle = '0;
		in_ch.gyro_rate = '0;
		in_ch.time_step = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes at reset noise values
		send_sample(0, 0, 16'd0);
		send_sample(32'sh7fffffff, 0, 16'd655);
		send_sample(32'sh80000000, 0, 16'd655);
		send_sample(0, 32'sh7fffffff, 16'hffff);
		send_sample(0, 32'sh80000000, 16'hffff);
		send_sample(32'sh7fffffff, 32'sh7fffffff, 16'hffff);
		send_sample(32'sh80000000, 32'sh80000000, 16'hffff);
		send_sample(-1, 1, 16'd1);
		send_sample(65536, -65536, 16'd655);
		send_sample(int'(32'h55555555), int'(32'haaaaaaaa), 16'h5555);
		send_sample(int'(32'haaaaaaaa), int'(32'h55555555), 16'haaaa);
		drain();

		// zero measurement noise: gain one collapses P00, then a zero time step
		// leaves the innovation variance at exactly zero
		write_noise(RegMeasR, '0);
		write_noise(RegAngleQ, '0);
		send_sample(6553600, 0, 16'd0);
		send_sample(13107200, 0, 16'd0);
		send_sample(-13107200, 65536, 16'd0);
		drain();
		// huge noise drives the covariance into saturation, possibly negative
		write_noise(RegAngleQ, 31'h7fffffff);
		write_noise(RegBiasQ, 31'h7fffffff);
		send_sample(32'sh7fffffff, 32'sh80000000, 16'hffff);
		send_sample(32'sh80000000, 32'sh7fffffff, 16'hffff);
		send_sample(0, 0, 16'hffff);
		send_sample(100, -100, 16'h8000);
		drain();
		// index out of range must be ignored
		write_noise(2'd3, 31'd12345);

		cfg_sets = '{
			'{31'd655, 31'd655, 31'd655},
			'{31'h7fffffff, 31'h7fffffff, 31'h7fffffff},
			'{31'd0, 31'd0, 31'd1},
			'{31'd6553, 31'd65, 31'd32768},
			'{31'd0, 31'd0, 31'd0},
			'{31'd655, 31'd3, 31'd131072}
		};

		// random phases, each with its own noise setting
		for (int ph = 0; ph < 6; ph++) begin
			write_noise(RegAngleQ, cfg_sets[ph][0]);
			write_noise(RegBiasQ, cfg_sets[ph][1]);
			write_noise(RegMeasR, cfg_sets[ph][2]);
			if (ph < 2) begin
				send_idle_pct = 20; recv_idle_pct = 72;
			end else if (ph < 4) begin
				send_idle_pct = 72; recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			if (ph == 5) hold_req = 1'b1;
			for (int n = 0; n < 230; n++) begin
				random_sample(m, g, d);
				send_sample(m, g, d);
			end
			drain();
		end

		$display("Ran %0d samples, %0d results checked, over nine noise settings",
			sb.samples, sb.results);
		$display("with random idling, a long output hold-off and zero-variance gains.");
		if (sb.errors == 0 && sb.expected_angles.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d errors, %0d results outstanding", sb.errors,
				sb.expected_angles.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule
